// ===== design/stepper_command_sequencer_macros.svh =====
`ifndef STEPPER_COMMAND_SEQUENCER_MACROS_SVH
`define STEPPER_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define SCS_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define SCS_ASSERT_NXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== design/scs_pkg.sv =====
`default_nettype none

package scs_pkg;

  localparam int unsigned TICKS_PER_MS = 1000;
  localparam logic [15:0] MAGIC_RESET = 16'd69;

  localparam int TPM_W = $clog2(TICKS_PER_MS + 1);
  localparam int PROD_W = 15 + TPM_W;
  localparam longint unsigned SETTLE_PROD_MAX = 64'd32767 * TICKS_PER_MS;
  localparam longint unsigned SETTLE_TICKS_MAX =
    (SETTLE_PROD_MAX > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : SETTLE_PROD_MAX;
  localparam int SETTLE_W = $clog2(SETTLE_TICKS_MAX + 1);
  localparam int CNT_W = (SETTLE_W > 31) ? SETTLE_W : 31;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  typedef enum logic [1:0] {
    ST_NONE,
    ST_ACCEPTED,
    ST_BAD_MAGIC,
    ST_BUSY
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RESET,
    PH_WAKE,
    PH_ENABLE,
    PH_MSTEP,
    PH_DIR,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic [2:0] {
    K_RESET,
    K_WAKE,
    K_ENABLE,
    K_MSTEP,
    K_DIR,
    K_STEPS
  } resume_t;

  typedef struct packed {
    logic                is_tick;
    logic                bad_magic;
    logic [2:0]          ms;
    logic                dis;
    logic                slp;
    logic                rst;
    logic                dir;
    logic                settle_ok;
    logic [SETTLE_W-1:0] settle_ticks;
    logic [30:0]         hp;
    logic [30:0]         steps;
  } cmd_t;

  typedef struct packed {
    logic       enable_pin;
    logic       sleep_pin;
    logic       reset_pin;
    logic       step_pin;
    logic       dir_pin;
    logic [2:0] microstep_pins;
    logic       busy;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

// ===== design/scs_front.sv =====
`default_nettype none

module scs_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic signed [15:0]  cfg_wr_data,
  input  wire logic                operation,
  input  wire logic [2:0]          microstep_mode,
  input  wire logic                disable_after,
  input  wire logic                sleep_after,
  input  wire logic                reset_request,
  input  wire logic signed [15:0]  magic,
  input  wire logic signed [15:0]  settle_ms_request,
  input  wire logic [30:0]         half_period_us,
  input  wire logic signed [31:0]  step_count,
  output scs_pkg::cmd_t            cmd
);

  logic [15:0] magic_r;
  logic [15:0] magic_nxt;
  logic [31:0] neg_count;
  logic [scs_pkg::PROD_W-1:0] settle_prod;

  always_comb begin
    magic_nxt = magic_r;
    if (cfg_wr_en) begin
      magic_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= scs_pkg::MAGIC_RESET;
    end else begin
      magic_r <= magic_nxt;
    end
  end

  assign neg_count = 32'd0 - step_count;
  assign settle_prod = scs_pkg::PROD_W'(settle_ms_request[14:0])
                     * scs_pkg::PROD_W'(scs_pkg::TICKS_PER_MS);

  always_comb begin
    cmd.is_tick   = operation;
    cmd.bad_magic = (magic != magic_r);
    cmd.ms        = microstep_mode;
    cmd.dis       = disable_after;
    cmd.slp       = sleep_after;
    cmd.rst       = reset_request;
    cmd.dir       = !step_count[31];
    cmd.settle_ok = (settle_ms_request != 16'sd0) && !settle_ms_request[15];
    if (settle_prod > scs_pkg::PROD_W'(scs_pkg::SETTLE_TICKS_MAX)) begin
      cmd.settle_ticks = scs_pkg::SETTLE_W'(scs_pkg::SETTLE_TICKS_MAX);
    end else begin
      cmd.settle_ticks = scs_pkg::SETTLE_W'(settle_prod);
    end
    cmd.hp = half_period_us;
    if (!step_count[31]) begin
      cmd.steps = step_count[30:0];
    end else if (neg_count[31]) begin
      // most negative count saturates
      cmd.steps = '1;
    end else begin
      cmd.steps = neg_count[30:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/scs_queue.sv =====
`default_nettype none

module scs_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire scs_pkg::cmd_t wr_data,
  input  wire logic          pop,
  output logic               empty,
  output scs_pkg::cmd_t      rd_data
);

  scs_pkg::cmd_t mem_r [scs_pkg::IQ_DEPTH];
  logic [scs_pkg::IQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [scs_pkg::IQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [scs_pkg::IQ_PTR_W:0]   count_r, count_nxt;
  logic do_push, do_pop;

  assign full    = (count_r == (scs_pkg::IQ_PTR_W+1)'(scs_pkg::IQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == scs_pkg::IQ_PTR_W'(scs_pkg::IQ_DEPTH - 1)) ? '0
                 : wr_ptr_r + scs_pkg::IQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == scs_pkg::IQ_PTR_W'(scs_pkg::IQ_DEPTH - 1)) ? '0
                 : rd_ptr_r + scs_pkg::IQ_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/scs_back.sv =====
`default_nettype none

module scs_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire scs_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire logic          out_pop,
  output logic               out_empty,
  output scs_pkg::result_t   out_res
);

  scs_pkg::phase_t phase_r, phase_nxt;
  logic [scs_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [30:0]                  steps_r, steps_nxt;
  logic [scs_pkg::SETTLE_W-1:0] settle_r, settle_nxt;
  logic en_r, en_nxt, slp_r, slp_nxt, rst_r, rst_nxt, stp_r, stp_nxt, dir_r, dir_nxt;
  logic [2:0] ms_r, ms_nxt;
  logic [2:0] lc_ms_r, lc_ms_nxt;
  logic lc_dis_r, lc_dis_nxt, lc_slp_r, lc_slp_nxt, lc_rst_r, lc_rst_nxt;
  logic lc_dir_r, lc_dir_nxt;
  logic [30:0] lc_hp_r, lc_hp_nxt;

  logic fire;
  scs_pkg::status_t status;
  scs_pkg::result_t res;

  scs_pkg::result_t oq_mem_r [scs_pkg::OQ_DEPTH];
  logic [scs_pkg::OQ_PTR_W-1:0] oq_wr_r, oq_wr_nxt, oq_rd_r, oq_rd_nxt;
  logic [scs_pkg::OQ_PTR_W:0]   oq_cnt_r, oq_cnt_nxt;
  logic oq_full, oq_pop;

  // sequencer next state
  always_comb begin
    logic proceed;
    scs_pkg::resume_t k;
    logic [scs_pkg::CNT_W-1:0] hp_cur;
    logic [scs_pkg::CNT_W-1:0] hp_new;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    steps_nxt  = steps_r;
    settle_nxt = settle_r;
    en_nxt     = en_r;
    slp_nxt    = slp_r;
    rst_nxt    = rst_r;
    stp_nxt    = stp_r;
    dir_nxt    = dir_r;
    ms_nxt     = ms_r;
    lc_ms_nxt  = lc_ms_r;
    lc_dis_nxt = lc_dis_r;
    lc_slp_nxt = lc_slp_r;
    lc_rst_nxt = lc_rst_r;
    lc_dir_nxt = lc_dir_r;
    lc_hp_nxt  = lc_hp_r;
    proceed    = 1'b0;
    k          = scs_pkg::K_RESET;
    hp_cur     = (lc_hp_r == '0) ? scs_pkg::CNT_W'(1) : scs_pkg::CNT_W'(lc_hp_r);
    if (fire) begin
      if (cmd.is_tick) begin
        if (phase_r != scs_pkg::PH_IDLE) begin
          if (cnt_r > scs_pkg::CNT_W'(1)) begin
            cnt_nxt = cnt_r - scs_pkg::CNT_W'(1);
          end else begin
            cnt_nxt = '0;
            case (phase_r)
              scs_pkg::PH_RESET: begin
                rst_nxt = 1'b1;
                proceed = 1'b1;
                k       = scs_pkg::K_WAKE;
              end
              scs_pkg::PH_WAKE: begin
                proceed = 1'b1;
                k       = scs_pkg::K_ENABLE;
              end
              scs_pkg::PH_ENABLE: begin
                proceed = 1'b1;
                k       = scs_pkg::K_MSTEP;
              end
              scs_pkg::PH_MSTEP: begin
                proceed = 1'b1;
                k       = scs_pkg::K_DIR;
              end
              scs_pkg::PH_DIR: begin
                proceed = 1'b1;
                k       = scs_pkg::K_STEPS;
              end
              scs_pkg::PH_HIGH: begin
                stp_nxt   = 1'b0;
                cnt_nxt   = hp_cur;
                phase_nxt = scs_pkg::PH_LOW;
              end
              scs_pkg::PH_LOW: begin
                if (steps_r != '0) begin
                  steps_nxt = steps_r - 31'd1;
                end
                proceed = 1'b1;
                k       = scs_pkg::K_STEPS;
              end
              default: begin
                phase_nxt = scs_pkg::PH_IDLE;
              end
            endcase
          end
        end
      end else if (phase_r == scs_pkg::PH_IDLE && !cmd.bad_magic) begin
        if (cmd.settle_ok) begin
          settle_nxt = cmd.settle_ticks;
        end
        steps_nxt  = cmd.steps;
        lc_ms_nxt  = cmd.ms;
        lc_dis_nxt = cmd.dis;
        lc_slp_nxt = cmd.slp;
        lc_rst_nxt = cmd.rst;
        lc_dir_nxt = cmd.dir;
        lc_hp_nxt  = cmd.hp;
        proceed    = 1'b1;
        k          = scs_pkg::K_RESET;
      end
    end
    hp_new = (lc_hp_nxt == '0) ? scs_pkg::CNT_W'(1) : scs_pkg::CNT_W'(lc_hp_nxt);
    if (proceed) begin
      if (k == scs_pkg::K_RESET && lc_rst_nxt) begin
        rst_nxt   = 1'b0;
        cnt_nxt   = scs_pkg::CNT_W'(settle_nxt);
        phase_nxt = scs_pkg::PH_RESET;
      end else if (steps_nxt != '0) begin
        if (k <= scs_pkg::K_WAKE && !slp_nxt) begin
          slp_nxt   = 1'b1;
          cnt_nxt   = scs_pkg::CNT_W'(settle_nxt);
          phase_nxt = scs_pkg::PH_WAKE;
        end else if (k <= scs_pkg::K_ENABLE && en_nxt) begin
          en_nxt    = 1'b0;
          cnt_nxt   = scs_pkg::CNT_W'(settle_nxt);
          phase_nxt = scs_pkg::PH_ENABLE;
        end else if (k <= scs_pkg::K_MSTEP && ms_nxt != lc_ms_nxt) begin
          ms_nxt    = lc_ms_nxt;
          cnt_nxt   = scs_pkg::CNT_W'(settle_nxt);
          phase_nxt = scs_pkg::PH_MSTEP;
        end else if (k <= scs_pkg::K_DIR && dir_nxt != lc_dir_nxt) begin
          dir_nxt   = lc_dir_nxt;
          cnt_nxt   = scs_pkg::CNT_W'(settle_nxt);
          phase_nxt = scs_pkg::PH_DIR;
        end else begin
          stp_nxt   = 1'b1;
          cnt_nxt   = hp_new;
          phase_nxt = scs_pkg::PH_HIGH;
        end
      end else begin
        if (lc_dis_nxt) begin
          en_nxt = 1'b1;
        end
        if (lc_slp_nxt) begin
          slp_nxt = 1'b0;
        end
        cnt_nxt   = '0;
        phase_nxt = scs_pkg::PH_IDLE;
      end
    end
  end

  // handshake, status and result word
  always_comb begin
    fire    = cmd_valid && (!oq_full || oq_pop);
    cmd_pop = fire;
    if (cmd.is_tick) begin
      status = scs_pkg::ST_NONE;
    end else if (phase_r != scs_pkg::PH_IDLE) begin
      status = scs_pkg::ST_BUSY;
    end else if (cmd.bad_magic) begin
      status = scs_pkg::ST_BAD_MAGIC;
    end else begin
      status = scs_pkg::ST_ACCEPTED;
    end
    res.enable_pin     = en_nxt;
    res.sleep_pin      = slp_nxt;
    res.reset_pin      = rst_nxt;
    res.step_pin       = stp_nxt;
    res.dir_pin        = dir_nxt;
    res.microstep_pins = ms_nxt;
    res.busy           = (phase_nxt != scs_pkg::PH_IDLE);
    res.status         = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= scs_pkg::PH_IDLE;
      cnt_r    <= '0;
      steps_r  <= '0;
      settle_r <= scs_pkg::SETTLE_W'(scs_pkg::TICKS_PER_MS);
      en_r     <= 1'b1;
      slp_r    <= 1'b0;
      rst_r    <= 1'b1;
      stp_r    <= 1'b0;
      dir_r    <= 1'b1;
      ms_r     <= '0;
      lc_ms_r  <= '0;
      lc_dis_r <= 1'b0;
      lc_slp_r <= 1'b0;
      lc_rst_r <= 1'b0;
      lc_dir_r <= 1'b0;
      lc_hp_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      steps_r  <= steps_nxt;
      settle_r <= settle_nxt;
      en_r     <= en_nxt;
      slp_r    <= slp_nxt;
      rst_r    <= rst_nxt;
      stp_r    <= stp_nxt;
      dir_r    <= dir_nxt;
      ms_r     <= ms_nxt;
      lc_ms_r  <= lc_ms_nxt;
      lc_dis_r <= lc_dis_nxt;
      lc_slp_r <= lc_slp_nxt;
      lc_rst_r <= lc_rst_nxt;
      lc_dir_r <= lc_dir_nxt;
      lc_hp_r  <= lc_hp_nxt;
    end
  end

  // result queue
  assign out_empty = (oq_cnt_r == '0);
  assign oq_full   = (oq_cnt_r == (scs_pkg::OQ_PTR_W+1)'(scs_pkg::OQ_DEPTH));
  assign oq_pop    = out_pop && !out_empty;
  assign out_res   = oq_mem_r[oq_rd_r];

  always_comb begin
    oq_wr_nxt  = oq_wr_r;
    oq_rd_nxt  = oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (fire) begin
      oq_wr_nxt = (oq_wr_r == scs_pkg::OQ_PTR_W'(scs_pkg::OQ_DEPTH - 1)) ? '0
                : oq_wr_r + scs_pkg::OQ_PTR_W'(1);
    end
    if (oq_pop) begin
      oq_rd_nxt = (oq_rd_r == scs_pkg::OQ_PTR_W'(scs_pkg::OQ_DEPTH - 1)) ? '0
                : oq_rd_r + scs_pkg::OQ_PTR_W'(1);
    end
    if (fire && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !fire) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/stepper_command_sequencer.sv =====
// Stepper command sequencer: drives enable, sleep, reset, step, direction and
// microstep pins of a step/direction driver from a stream of items.
// Input channel: queue-style push/full. Each item is a one-microsecond tick
// (in_operation = 1) or a motion command checked against the magic word.
// Result channel: queue-style empty/pop. Every item yields exactly one result
// transaction with the pin levels after that item, a busy flag and a status.
// Configuration: cfg_wr_en with cfg_wr_data writes the magic word at once.
// An item accepted into an empty block is registered in the command queue,
// then in the result queue, before it shows on the result ports. Throughput:
// one item per cycle, one step each, while the result queue can take a result.
// A four-entry command queue sits between the decoder and the sequencer, and
// a two-entry result queue sits at the output.
// When the receiver stops popping, the result queue fills, the sequencer
// holds, the command queue fills, and full rises; nothing is lost.
// Reset (rst_n low, synchronous) empties both queues, sets the magic word to
// 69, the settle time to 1 ms, returns to idle and puts the pins at disabled,
// asleep, reset released, step low, clockwise and full step.
`default_nettype none

`include "stepper_command_sequencer_macros.svh"

module stepper_command_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic signed [15:0] cfg_wr_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic               in_operation,
  input  wire logic [2:0]         in_microstep_mode,
  input  wire logic               in_disable_after,
  input  wire logic               in_sleep_after,
  input  wire logic               in_reset_request,
  input  wire logic signed [15:0] in_magic,
  input  wire logic signed [15:0] in_settle_ms_request,
  input  wire logic [30:0]        in_half_period_us,
  input  wire logic signed [31:0] in_step_count,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic                    out_enable_pin,
  output logic                    out_sleep_pin,
  output logic                    out_reset_pin,
  output logic                    out_step_pin,
  output logic                    out_dir_pin,
  output logic [2:0]              out_microstep_pins,
  output logic                    out_busy_res,
  output logic [1:0]              out_status
);

  scs_pkg::cmd_t    dec_cmd;
  scs_pkg::cmd_t    q_cmd;
  scs_pkg::result_t res;
  logic q_empty, q_pop;

  scs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .operation         (in_operation),
    .microstep_mode    (in_microstep_mode),
    .disable_after     (in_disable_after),
    .sleep_after       (in_sleep_after),
    .reset_request     (in_reset_request),
    .magic             (in_magic),
    .settle_ms_request (in_settle_ms_request),
    .half_period_us    (in_half_period_us),
    .step_count        (in_step_count),
    .cmd               (dec_cmd)
  );

  scs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .wr_data (dec_cmd),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_cmd)
  );

  scs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (!q_empty),
    .cmd_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_enable_pin     = res.enable_pin;
  assign out_sleep_pin      = res.sleep_pin;
  assign out_reset_pin      = res.reset_pin;
  assign out_step_pin       = res.step_pin;
  assign out_dir_pin        = res.dir_pin;
  assign out_microstep_pins = res.microstep_pins;
  assign out_busy_res       = res.busy;
  assign out_status         = res.status;

  `SCS_ASSERT_IMP(a_busy_status_busy, !out_empty && out_status == scs_pkg::ST_BUSY,
                  out_busy_res, "busy status without busy flag")
  `SCS_ASSERT_IMP(a_bad_magic_idle, !out_empty && out_status == scs_pkg::ST_BAD_MAGIC,
                  !out_busy_res, "bad magic result while busy")
  `SCS_ASSERT_IMP(a_idle_pins, !out_empty && !out_busy_res,
                  !out_step_pin && out_reset_pin, "idle result with step high or reset low")
  `SCS_ASSERT_NXT(a_full_holds, in_full && !q_pop, in_full,
                  "command queue full dropped without a pop")

endmodule

`default_nettype wire

// ===== test/tb_stepper_command_sequencer.sv =====
`default_nettype none

module tb_stepper_command_sequencer;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_BUDGET = 350;

  typedef struct {
    logic        op;
    logic [2:0]  ms;
    logic        dis;
    logic        slp;
    logic        rst;
    logic [15:0] magic;
    logic [15:0] settle;
    logic [30:0] hp;
    logic [31:0] steps;
  } item_t;

  typedef struct {
    logic [2:0]  ms;
    logic        dis;
    logic        slp;
    logic        rst;
    logic        dir;
    logic [30:0] hp;
  } held_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic signed [15:0] cfg_wr_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_operation = 1'b0;
  logic [2:0] in_microstep_mode = '0;
  logic in_disable_after = 1'b0;
  logic in_sleep_after = 1'b0;
  logic in_reset_request = 1'b0;
  logic signed [15:0] in_magic = '0;
  logic signed [15:0] in_settle_ms_request = '0;
  logic [30:0] in_half_period_us = '0;
  logic signed [31:0] in_step_count = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_enable_pin;
  logic out_sleep_pin;
  logic out_reset_pin;
  logic out_step_pin;
  logic out_dir_pin;
  logic [2:0] out_microstep_pins;
  logic out_busy_res;
  logic [1:0] out_status;

  // pin model state
  logic [15:0] magic_word = scs_pkg::MAGIC_RESET;
  logic pin_enable = 1'b1;
  logic pin_sleep = 1'b0;
  logic pin_reset = 1'b1;
  logic pin_step = 1'b0;
  logic pin_dir = 1'b1;
  logic [2:0] pin_mstep = '0;
  logic [14:0] settle_ms = 15'd1;
  scs_pkg::phase_t ph = scs_pkg::PH_IDLE;
  logic [31:0] countdown = '0;
  logic [30:0] steps_left = '0;
  held_cmd_t held = '{default: '0};

  scs_pkg::result_t pending_pins[$];
  scs_pkg::result_t want;
  int errors = 0;
  int motion_items = 0;
  int idle_cycles = 0;
  int send_idle = 32;
  int recv_idle = 80;

  stepper_command_sequencer i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_operation         (in_operation),
    .in_microstep_mode    (in_microstep_mode),
    .in_disable_after     (in_disable_after),
    .in_sleep_after       (in_sleep_after),
    .in_reset_request     (in_reset_request),
    .in_magic             (in_magic),
    .in_settle_ms_request (in_settle_ms_request),
    .in_half_period_us    (in_half_period_us),
    .in_step_count        (in_step_count),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_enable_pin       (out_enable_pin),
    .out_sleep_pin        (out_sleep_pin),
    .out_reset_pin        (out_reset_pin),
    .out_step_pin         (out_step_pin),
    .out_dir_pin          (out_dir_pin),
    .out_microstep_pins   (out_microstep_pins),
    .out_busy_res         (out_busy_res),
    .out_status           (out_status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_idle);
  end

  function automatic void start_settle(scs_pkg::phase_t nxt);
    longint unsigned t;
    t = 64'(settle_ms) * scs_pkg::TICKS_PER_MS;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    if (t == 0) t = 1;
    countdown = t[31:0];
    ph = nxt;
  endfunction

  function automatic void start_half(scs_pkg::phase_t nxt);
    countdown = (held.hp != 0) ? {1'b0, held.hp} : 32'd1;
    ph = nxt;
  endfunction

  function automatic void advance_sequence(scs_pkg::resume_t k);
    if (k <= scs_pkg::K_RESET && held.rst) begin
      pin_reset = 1'b0;
      start_settle(scs_pkg::PH_RESET);
      return;
    end
    if (steps_left != 0) begin
      if (k <= scs_pkg::K_WAKE && pin_sleep == 1'b0) begin
        pin_sleep = 1'b1;
        start_settle(scs_pkg::PH_WAKE);
        return;
      end
      if (k <= scs_pkg::K_ENABLE && pin_enable == 1'b1) begin
        pin_enable = 1'b0;
        start_settle(scs_pkg::PH_ENABLE);
        return;
      end
      if (k <= scs_pkg::K_MSTEP && pin_mstep != held.ms) begin
        pin_mstep = held.ms;
        start_settle(scs_pkg::PH_MSTEP);
        return;
      end
      if (k <= scs_pkg::K_DIR && pin_dir != held.dir) begin
        pin_dir = held.dir;
        start_settle(scs_pkg::PH_DIR);
        return;
      end
      pin_step = 1'b1;
      start_half(scs_pkg::PH_HIGH);
      return;
    end
    if (held.dis) pin_enable = 1'b1;
    if (held.slp) pin_sleep = 1'b0;
    ph = scs_pkg::PH_IDLE;
    countdown = '0;
  endfunction

  function automatic void expire_wait();
    case (ph)
      scs_pkg::PH_RESET: begin
        pin_reset = 1'b1;
        advance_sequence(scs_pkg::K_WAKE);
      end
      scs_pkg::PH_WAKE: advance_sequence(scs_pkg::K_ENABLE);
      scs_pkg::PH_ENABLE: advance_sequence(scs_pkg::K_MSTEP);
      scs_pkg::PH_MSTEP: advance_sequence(scs_pkg::K_DIR);
      scs_pkg::PH_DIR: advance_sequence(scs_pkg::K_STEPS);
      scs_pkg::PH_HIGH: begin
        pin_step = 1'b0;
        start_half(scs_pkg::PH_LOW);
      end
      scs_pkg::PH_LOW: begin
        if (steps_left != 0) steps_left--;
        advance_sequence(scs_pkg::K_STEPS);
      end
      default: begin
        ph = scs_pkg::PH_IDLE;
        countdown = '0;
      end
    endcase
  endfunction

  function automatic scs_pkg::result_t predict_pins(item_t it);
    scs_pkg::result_t r;
    scs_pkg::status_t st;
    logic [31:0] mag;
    logic d;
    st = scs_pkg::ST_NONE;
    if (it.op) begin
      if (ph != scs_pkg::PH_IDLE) begin
        if (countdown > 1) countdown--;
        else begin
          countdown = '0;
          expire_wait();
        end
      end
    end else if (ph != scs_pkg::PH_IDLE) begin
      st = scs_pkg::ST_BUSY;
    end else if (it.magic != magic_word) begin
      st = scs_pkg::ST_BAD_MAGIC;
    end else begin
      st = scs_pkg::ST_ACCEPTED;
      if (it.settle != 0 && !it.settle[15]) settle_ms = it.settle[14:0];
      if (it.steps[31]) begin
        mag = 32'd0 - it.steps;
        d = 1'b0;
      end else begin
        mag = it.steps;
        d = 1'b1;
      end
      if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
      steps_left = mag[30:0];
      held = '{ms: it.ms, dis: it.dis, slp: it.slp, rst: it.rst, dir: d, hp: it.hp};
      advance_sequence(scs_pkg::K_RESET);
    end
    r.enable_pin = pin_enable;
    r.sleep_pin = pin_sleep;
    r.reset_pin = pin_reset;
    r.step_pin = pin_step;
    r.dir_pin = pin_dir;
    r.microstep_pins = pin_mstep;
    r.busy = (ph != scs_pkg::PH_IDLE);
    r.status = st;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] exp);
    if (got !== exp) report_error($sformatf("%s got %0d expected %0d", name, got, exp));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_pins.size() == 0) begin
        report_error("result transaction with no expectation");
      end else begin
        want = pending_pins.pop_front();
        check_field("enable_pin", 3'(out_enable_pin), 3'(want.enable_pin));
        check_field("sleep_pin", 3'(out_sleep_pin), 3'(want.sleep_pin));
        check_field("reset_pin", 3'(out_reset_pin), 3'(want.reset_pin));
        check_field("step_pin", 3'(out_step_pin), 3'(want.step_pin));
        check_field("dir_pin", 3'(out_dir_pin), 3'(want.dir_pin));
        check_field("microstep_pins", out_microstep_pins, want.microstep_pins);
        check_field("busy_res", 3'(out_busy_res), 3'(want.busy));
        check_field("status", 3'(out_status), 3'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.op = 1'($urandom);
    it.ms = 3'($urandom);
    it.dis = 1'($urandom);
    it.slp = 1'($urandom);
    it.rst = 1'($urandom);
    it.magic = 16'($urandom);
    it.settle = 16'($urandom);
    it.hp = 31'($urandom);
    it.steps = $urandom;
    return it;
  endfunction

  function automatic item_t motion_cmd(logic [2:0] ms, logic dis, logic slp, logic rst,
                                       logic [15:0] settle, logic [30:0] hp,
                                       logic [31:0] steps);
    item_t it;
    it = '{op: 1'b0, ms: ms, dis: dis, slp: slp, rst: rst, magic: magic_word,
           settle: settle, hp: hp, steps: steps};
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_operation <= it.op;
    in_microstep_mode <= it.ms;
    in_disable_after <= it.dis;
    in_sleep_after <= it.slp;
    in_reset_request <= it.rst;
    in_magic <= it.magic;
    in_settle_ms_request <= it.settle;
    in_half_period_us <= it.hp;
    in_step_count <= it.steps;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (!it.op || ph == scs_pkg::PH_HIGH || ph == scs_pkg::PH_LOW) motion_items++;
    pending_pins.push_back(predict_pins(it));
  endtask

  task automatic send_tick();
    item_t it;
    it = random_item();
    it.op = 1'b1;
    send_item(it);
  endtask

  // commands arriving mid-sequence must be refused as busy
  task automatic finish_motion();
    item_t it;
    while (ph != scs_pkg::PH_IDLE) begin
      it = random_item();
      it.op = ($urandom_range(99) >= 3);
      if (!it.op && $urandom_range(1)) it.magic = magic_word;
      send_item(it);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  task automatic write_magic(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    magic_word = value;
  endtask

  task automatic test_idle_commands();
    item_t it;
    send_tick();
    it = random_item();
    it.op = 1'b0;
    it.magic = magic_word ^ 16'h0001;
    send_item(it);
    // zero steps and no reset: done on the same transaction
    send_item(motion_cmd(3'd7, 1'b0, 1'b0, 1'b0, 16'h7FFF, 31'h7FFF_FFFF, 32'd0));
    send_item(motion_cmd(3'd0, 1'b1, 1'b1, 1'b0, 16'h8000, 31'd0, 32'd0));
    send_item(motion_cmd(3'd0, 1'b0, 1'b0, 1'b0, 16'd1, 31'd0, 32'd0));
  endtask

  task automatic test_reset_pulse();
    item_t it;
    send_item(motion_cmd(3'd2, 1'b1, 1'b1, 1'b1, 16'd0, 31'd5, 32'd0));
    it = random_item();
    it.op = 1'b0;
    it.magic = magic_word ^ 16'h8000;
    send_item(it);
    send_item(motion_cmd(3'd1, 1'b0, 1'b0, 1'b0, 16'd0, 31'd0, 32'd1));
    finish_motion();
  endtask

  task automatic test_wake_and_step();
    send_item(motion_cmd(3'd7, 1'b0, 1'b0, 1'b1, 16'd0, 31'd0, 32'd3));
    finish_motion();
  endtask

  task automatic test_direction_change();
    send_item(motion_cmd(3'd7, 1'b1, 1'b1, 1'b0, 16'd2, 31'd2, -32'sd2));
    finish_motion();
    send_item(motion_cmd(3'd3, 1'b0, 1'b0, 1'b0, 16'd1, 31'd1, 32'd1));
    finish_motion();
  endtask

  task automatic test_random_motion(input int budget);
    int start;
    int r;
    int unsigned mag;
    logic new_dir;
    item_t c;
    start = motion_items;
    while (motion_items - start < budget) begin
      r = $urandom_range(99);
      c = random_item();
      c.op = 1'b0;
      if (r < 4) begin
        send_tick();
      end else if (r < 12) begin
        if (c.magic == magic_word) c.magic[0] = ~c.magic[0];
        send_item(c);
      end else begin
        c.magic = magic_word;
        r = $urandom_range(99);
        if (r < 25) mag = 0;
        else if (r < 90) mag = $urandom_range(1, 6);
        else mag = $urandom_range(7, 40);
        new_dir = ($urandom_range(9) == 0) ? ~pin_dir : pin_dir;
        c.steps = new_dir ? mag : 32'd0 - mag;
        if (mag != 0) begin
          c.hp = ($urandom_range(9) == 0) ? 31'($urandom_range(4, 12))
                                          : 31'($urandom_range(3));
        end
        if ($urandom_range(99) < 93) c.ms = pin_mstep;
        c.dis = ($urandom_range(99) < 8);
        c.slp = ($urandom_range(99) < 8);
        c.rst = ($urandom_range(99) < 4);
        r = $urandom_range(99);
        if (r < 55) c.settle = 16'd0;
        else if (r < 85) c.settle = {1'b1, 15'($urandom)};
        else if (r < 97) c.settle = 16'd1;
        else c.settle = 16'd2;
        send_item(c);
        finish_motion();
      end
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  // most negative count saturates to the largest step count, so the sequence outlasts the test
  task automatic test_saturated_steps();
    send_item(motion_cmd(3'($urandom), 1'b0, 1'b0, 1'b0, 16'd1, 31'd0, 32'h8000_0000));
    while (ph != scs_pkg::PH_HIGH) send_tick();
    repeat (40) send_tick();
    send_item(motion_cmd(3'd0, 1'b0, 1'b0, 1'b0, 16'd0, 31'd0, 32'd1));
    repeat (5) send_tick();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_commands();
    test_reset_pulse();
    test_wake_and_step();
    test_direction_change();
    drain();
    write_magic(16'h8000);
    test_random_motion(RANDOM_BUDGET);
    drain();
    send_idle = 80;
    recv_idle = 32;
    write_magic(16'h7FFF);
    test_random_motion(RANDOM_BUDGET);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_magic(16'($urandom));
    test_random_motion(RANDOM_BUDGET);
    test_saturated_steps();
    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
